[hdl/rcyl_pkg.sv]
// Package for the capped cylinder intersect pipeline: constants, stage types, arithmetic helpers.
package rcyl_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 65 - FRAC_BITS;
   localparam int SQRT_W    = (32 + FRAC_BITS) / 2;
   localparam int SQ_V_W    = 2 * SQRT_W;
   localparam int SQ_REM_W  = SQRT_W + 1;
   localparam int SQ_PER    = 3;
   localparam int SQ_STAGES = (SQRT_W + SQ_PER - 1) / SQ_PER;
   localparam int NUM_W     = 34;
   localparam int DIV_BITS  = 32;
   localparam int DV_PER    = 4;
   localparam int DV_STAGES = DIV_BITS / DV_PER;
   localparam int LANES     = 4;

   localparam int LN_T1  = 0;
   localparam int LN_T2  = 1;
   localparam int LN_ZLO = 2;
   localparam int LN_ZHI = 3;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;
   localparam logic [15:0]        EPS_RESET = 16'd1;

   typedef enum logic [2:0] {
      ST_MISS   = 3'd0,
      ST_FAR    = 3'd1,
      ST_ENTER  = 3'd2,
      ST_EXIT   = 3'd3,
      ST_BEHIND = 3'd4
   } status_type;

   typedef struct packed {
      logic [30:0] lam;
      logic        miss;
      logic        dz_pos;
      logic        dz_neg;
      logic        par_out;
   } flag_type;

   typedef struct packed {
      logic signed [63:0] xx;
      logic signed [63:0] yy;
      logic signed [63:0] xo;
      logic signed [63:0] yo;
      logic signed [63:0] ox2;
      logic signed [63:0] oy2;
      logic signed [31:0] oz;
      logic signed [31:0] dz;
      logic [30:0]        lam;
   } prod_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] oz;
      logic signed [31:0] dz;
      logic [30:0]        lam;
   } coef_type;

   typedef struct packed {
      logic signed [63:0] bb;
      logic signed [63:0] ac;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] oz;
      logic signed [31:0] dz;
      logic [30:0]        lam;
   } disc_type;

   typedef struct packed {
      logic [SQ_V_W-1:0]   v;
      logic [SQ_REM_W-1:0] rem;
      logic [SQRT_W-1:0]   root;
      logic signed [31:0]  a;
      logic signed [31:0]  b;
      logic signed [31:0]  oz;
      logic signed [31:0]  dz;
      flag_type            f;
   } sq_type;

   typedef struct packed {
      logic [31:0] low;
      logic [31:0] rem;
      logic [31:0] q;
      logic [31:0] den;
      logic        neg;
      logic        ovf;
   } dl_type;

   typedef struct packed {
      dl_type [LANES-1:0] ln;
      flag_type           f;
   } dv_type;

   typedef struct packed {
      logic signed [31:0] t1;
      logic signed [31:0] t2;
      logic signed [31:0] zlo;
      logic signed [31:0] zhi;
      flag_type           f;
   } fx_type;

   // floor shift of an exact product
   function automatic logic signed [SUM_W-1:0] shq(input logic signed [63:0] p);
      return {p[63], p[63:FRAC_BITS]};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-32:0] top;
      top = v[SUM_W-1:31];
      if (&top || ~|top) return v[31:0];
      return v[SUM_W-1] ? Q_MIN : Q_MAX;
   endfunction

   // one result bit of the integer square root
   function automatic sq_type sq_step(input sq_type x);
      sq_type            r;
      logic [SQRT_W+2:0] rsh;
      logic [SQRT_W+2:0] trial;
      r     = x;
      rsh   = {x.rem, x.v[SQ_V_W-1 -: 2]};
      trial = {1'b0, x.root, 2'b01};
      r.v   = x.v << 2;
      if (rsh >= trial) begin
         r.rem  = SQ_REM_W'(rsh - trial);
         r.root = {x.root[SQRT_W-2:0], 1'b1};
      end else begin
         r.rem  = rsh[SQ_REM_W-1:0];
         r.root = {x.root[SQRT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // magnitude setup; the upper dividend bits seed the remainder, overflow if they reach den
   function automatic dl_type div_init(input logic signed [NUM_W-1:0] num,
                                       input logic signed [31:0] den);
      dl_type               r;
      logic [NUM_W-1:0]     mag_n;
      logic [31:0]          mag_d;
      logic [FRAC_BITS-1:0] top;
      mag_n = num[NUM_W-1] ? NUM_W'(-num) : num;
      mag_d = den[31] ? 32'(-den) : den;
      top   = mag_n[31 -: FRAC_BITS];
      r.den = mag_d;
      r.neg = num[NUM_W-1] ^ den[31];
      r.ovf = 32'(top) >= mag_d;
      r.rem = 32'(top);
      r.low = {mag_n[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      r.q   = '0;
      return r;
   endfunction

   function automatic dl_type div_step(input dl_type x);
      dl_type      r;
      logic [32:0] rsh;
      r     = x;
      rsh   = {x.rem, x.low[31]};
      r.low = x.low << 1;
      if (rsh >= {1'b0, x.den}) begin
         r.rem = 32'(rsh - {1'b0, x.den});
         r.q   = {x.q[30:0], 1'b1};
      end else begin
         r.rem = rsh[31:0];
         r.q   = {x.q[30:0], 1'b0};
      end
      return r;
   endfunction

   // apply sign, saturate to signed 32
   function automatic logic signed [31:0] div_result(input dl_type x);
      if (!x.neg) begin
         if (x.ovf || x.q[31]) return Q_MAX;
         return x.q;
      end
      if (x.ovf || (x.q[31] && x.q[30:0] != '0)) return Q_MIN;
      return 32'(-x.q);
   endfunction

endpackage

[hdl/ray_capped_cylinder_intersect.sv]
// Ray against capped unit cylinder along Z: fixed-point pipelined intersect and classify.
// Pipeline of 4 multiply/saturate stages, 8 square-root stages at 3 root bits each, 1 divide
//   setup, 8 divide stages at 4 quotient bits each, 1 quotient fixup stage and the output
//   register.
// Throughput: one ray per cycle; the whole pipe holds while a result is stalled at the output.
// Reset: clears all stage valid bits and sets epsilon to 1; data registers are not reset.
module ray_capped_cylinder_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [30:0]        req_max_distance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [30:0]        rsp_hit_distance,
   output logic [2:0]         rsp_status_code
);
   import rcyl_pkg::*;

   logic               adv;
   logic [15:0]        eps_ff;
   logic signed [31:0] eps_s;

   prod_type s1_ff, s1_in;
   coef_type s2_ff, s2_in;
   disc_type s3_ff, s3_in;
   logic     s1v_ff, s2v_ff, s3v_ff;

   sq_type sq_ff [0:SQ_STAGES];
   sq_type sq_in [0:SQ_STAGES];
   logic [SQ_STAGES:0] sqv_ff;

   dv_type dv_ff [0:DV_STAGES];
   dv_type dv_in [0:DV_STAGES];
   logic [DV_STAGES:0] dvv_ff;

   fx_type fx_ff, fx_in;
   logic   fxv_ff;

   logic        rsp_valid_ff;
   logic        rsp_hit_ff, rsp_hit_in;
   logic [30:0] rsp_dist_ff, rsp_dist_in;
   status_type  rsp_status_ff, rsp_status_in;

   assign eps_s     = signed'({16'b0, eps_ff});
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_write_enable) begin
         eps_ff <= csr_write_data;
      end
   end

   // products
   always_comb begin
      s1_in.xx  = 64'(req_dir_x) * 64'(req_dir_x);
      s1_in.yy  = 64'(req_dir_y) * 64'(req_dir_y);
      s1_in.xo  = 64'(req_dir_x) * 64'(req_origin_x);
      s1_in.yo  = 64'(req_dir_y) * 64'(req_origin_y);
      s1_in.ox2 = 64'(req_origin_x) * 64'(req_origin_x);
      s1_in.oy2 = 64'(req_origin_y) * 64'(req_origin_y);
      s1_in.oz  = req_origin_z;
      s1_in.dz  = req_dir_z;
      s1_in.lam = req_max_distance;
   end

   // quadratic coefficients
   always_comb begin
      s2_in.a   = sat32(shq(s1_ff.xx) + shq(s1_ff.yy));
      s2_in.b   = sat32(shq(s1_ff.xo) + shq(s1_ff.yo));
      s2_in.c   = sat32(shq(s1_ff.ox2) + shq(s1_ff.oy2) - SUM_W'(ONE_Q));
      s2_in.oz  = s1_ff.oz;
      s2_in.dz  = s1_ff.dz;
      s2_in.lam = s1_ff.lam;
   end

   always_comb begin
      s3_in.bb  = 64'(s2_ff.b) * 64'(s2_ff.b);
      s3_in.ac  = 64'(s2_ff.a) * 64'(s2_ff.c);
      s3_in.a   = s2_ff.a;
      s3_in.b   = s2_ff.b;
      s3_in.oz  = s2_ff.oz;
      s3_in.dz  = s2_ff.dz;
      s3_in.lam = s2_ff.lam;
   end

   // discriminant, early-out flags, then the root stages
   always_comb begin : c_sq
      logic signed [31:0] d;
      sq_type             x;
      d                  = sat32(shq(s3_ff.bb) - shq(s3_ff.ac));
      sq_in[0].v         = SQ_V_W'(d[30:0]) << FRAC_BITS;
      sq_in[0].rem       = '0;
      sq_in[0].root      = '0;
      sq_in[0].a         = s3_ff.a;
      sq_in[0].b         = s3_ff.b;
      sq_in[0].oz        = s3_ff.oz;
      sq_in[0].dz        = s3_ff.dz;
      sq_in[0].f.lam     = s3_ff.lam;
      sq_in[0].f.miss    = (s3_ff.a <= eps_s) || (d < eps_s);
      sq_in[0].f.dz_pos  = s3_ff.dz > eps_s;
      sq_in[0].f.dz_neg  = s3_ff.dz < -eps_s;
      sq_in[0].f.par_out = !(s3_ff.dz > eps_s) && !(s3_ff.dz < -eps_s)
                           && (s3_ff.oz < 0 || s3_ff.oz > ONE_Q);
      for (int s = 1; s <= SQ_STAGES; s++) begin
         x = sq_ff[s-1];
         for (int j = 0; j < SQ_PER; j++) begin
            if ((s - 1) * SQ_PER + j < SQRT_W) x = sq_step(x);
         end
         sq_in[s] = x;
      end
   end

   // divider setup: roots over a, slab planes over dz, four lanes in parallel
   always_comb begin : c_dv
      logic signed [NUM_W-1:0] nb, rt, zn0, zn1;
      dv_type                  x;
      sq_type                  q;
      q   = sq_ff[SQ_STAGES];
      nb  = -NUM_W'(q.b);
      rt  = NUM_W'(q.root);
      zn0 = -NUM_W'(q.oz);
      zn1 = NUM_W'(ONE_Q) - NUM_W'(q.oz);
      dv_in[0].f          = q.f;
      dv_in[0].ln[LN_T1]  = div_init(nb - rt, q.a);
      dv_in[0].ln[LN_T2]  = div_init(nb + rt, q.a);
      dv_in[0].ln[LN_ZLO] = div_init(q.f.dz_pos ? zn0 : zn1, q.dz);
      dv_in[0].ln[LN_ZHI] = div_init(q.f.dz_pos ? zn1 : zn0, q.dz);
      for (int s = 1; s <= DV_STAGES; s++) begin
         x = dv_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < DV_PER; j++) begin
               x.ln[l] = div_step(x.ln[l]);
            end
         end
         dv_in[s] = x;
      end
   end

   always_comb begin
      fx_in.t1  = div_result(dv_ff[DV_STAGES].ln[LN_T1]);
      fx_in.t2  = div_result(dv_ff[DV_STAGES].ln[LN_T2]);
      fx_in.zlo = div_result(dv_ff[DV_STAGES].ln[LN_ZLO]);
      fx_in.zhi = div_result(dv_ff[DV_STAGES].ln[LN_ZHI]);
      fx_in.f   = dv_ff[DV_STAGES].f;
   end

   // interval cut and classification
   always_comb begin : c_cls
      logic signed [31:0] lam_s, lo, hi;
      lam_s = signed'({1'b0, fx_ff.f.lam});
      lo    = eps_s;
      hi    = lam_s;
      if (fx_ff.f.dz_pos || fx_ff.f.dz_neg) begin
         lo = fx_ff.zlo;
         hi = fx_ff.zhi;
      end
      if (lo < fx_ff.t1) lo = fx_ff.t1;
      if (fx_ff.t2 < hi) hi = fx_ff.t2;
      rsp_dist_in = fx_ff.f.lam;
      priority if (fx_ff.f.miss || fx_ff.f.par_out || hi < lo) begin
         rsp_status_in = ST_MISS;
      end else if (lam_s < lo) begin
         rsp_status_in = ST_FAR;
      end else if (eps_s < lo) begin
         rsp_status_in = ST_ENTER;
         rsp_dist_in   = lo[30:0];
      end else if (lam_s < hi) begin
         rsp_status_in = ST_FAR;
      end else if (eps_s < hi) begin
         rsp_status_in = ST_EXIT;
         rsp_dist_in   = hi[30:0];
      end else begin
         rsp_status_in = ST_BEHIND;
      end
      rsp_hit_in = (rsp_status_in == ST_ENTER) || (rsp_status_in == ST_EXIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff       <= 1'b0;
         s2v_ff       <= 1'b0;
         s3v_ff       <= 1'b0;
         sqv_ff       <= '0;
         dvv_ff       <= '0;
         fxv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1v_ff       <= req_valid;
         s2v_ff       <= s1v_ff;
         s3v_ff       <= s2v_ff;
         sqv_ff       <= {sqv_ff[SQ_STAGES-1:0], s3v_ff};
         dvv_ff       <= {dvv_ff[DV_STAGES-1:0], sqv_ff[SQ_STAGES]};
         fxv_ff       <= dvv_ff[DV_STAGES];
         rsp_valid_ff <= fxv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         for (int s = 0; s <= SQ_STAGES; s++) sq_ff[s] <= sq_in[s];
         for (int s = 0; s <= DV_STAGES; s++) dv_ff[s] <= dv_in[s];
         fx_ff         <= fx_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_dist_ff;
   assign rsp_status_code  = rsp_status_ff;

   // a held pipe must not gain or drop any item
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({s1v_ff, s2v_ff, s3v_ff, sqv_ff, dvv_ff, fxv_ff}))
      else $error("pipeline valid bits moved during a hold");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no result waiting");

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_hit_ff == (rsp_status_ff == ST_ENTER || rsp_status_ff == ST_EXIT))
      else $error("hit flag disagrees with status");

   a_hit_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_dist_ff > {15'b0, eps_ff})
      else $error("hit distance not in front of the origin");

endmodule

[dv/tb.sv]
// Self-checking testbench for the capped cylinder ray intersect pipeline.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcyl_pkg::*;

   localparam int LATENCY   = 22;
   localparam int N_RANDOM  = 1400;
   localparam longint LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic [30:0]        lam;
   } ray_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] hit_dist;
      status_type  status;
   } isect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ray_type     req_ray = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [30:0] rsp_hit_distance;
   logic [2:0]  rsp_status_code;

   ray_type   ray_queue[$];
   isect_type expected_hits[$];
   logic [15:0] eps_q = EPS_RESET;
   int  mismatches = 0;
   int  rays_sent = 0;
   int  rays_checked = 0;
   int  status_seen[5] = '{default: 0};
   longint cycle_count = 0;
   bit  driver_paused = 1'b0;
   bit  hold_rsp = 1'b0;
   bit  req_taken = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  hold_left = 0;

   ray_capped_cylinder_intersect uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_ray.ox), .req_origin_y(req_ray.oy), .req_origin_z(req_ray.oz),
      .req_dir_x(req_ray.dx), .req_dir_y(req_ray.dy), .req_dir_z(req_ray.dz),
      .req_max_distance(req_ray.lam),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_hit_distance(rsp_hit_distance), .rsp_status_code(rsp_status_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fixed-point helpers: floor-shifted product, saturation, divide, root
   function automatic longint fxmul(longint x, longint y);
      return (x * y) >>> FRAC_BITS;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fxdiv(longint num, longint den);
      return clamp32((num * (64'sd1 <<< FRAC_BITS)) / den);
   endfunction

   function automatic longint fxsqrt(longint d);
      longint unsigned v, r, bitv;
      v = longint'(d) << FRAC_BITS;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic isect_type intersect_cylinder(ray_type ray, logic [15:0] eps_v);
      isect_type res;
      longint one, ox, oy, oz, dx, dy, dz, lam, eps, a, b, c, d, lo, hi, t1, t2, dist_v;
      status_type st;
      one = 64'sd1 <<< FRAC_BITS;
      ox = ray.ox; oy = ray.oy; oz = ray.oz;
      dx = ray.dx; dy = ray.dy; dz = ray.dz;
      lam = longint'(ray.lam);
      eps = longint'(eps_v);
      dist_v = lam;
      a = clamp32(fxmul(dx, dx) + fxmul(dy, dy));
      b = clamp32(fxmul(dx, ox) + fxmul(dy, oy));
      c = clamp32(fxmul(ox, ox) + fxmul(oy, oy) - one);
      d = clamp32(fxmul(b, b) - fxmul(a, c));
      if (a <= eps || d < eps) begin
         st = ST_MISS;
      end else begin
         d = fxsqrt(d);
         lo = eps;
         hi = lam;
         if (dz > eps) begin
            lo = fxdiv(-oz, dz);
            hi = fxdiv(one - oz, dz);
         end else if (dz < -eps) begin
            lo = fxdiv(one - oz, dz);
            hi = fxdiv(-oz, dz);
         end
         t1 = fxdiv(-b - d, a);
         t2 = fxdiv(-b + d, a);
         if (lo < t1) lo = t1;
         if (t2 < hi) hi = t2;
         if (dz >= -eps && dz <= eps && (oz < 0 || oz > one)) st = ST_MISS;
         else if (hi < lo) st = ST_MISS;
         else if (lam < lo) st = ST_FAR;
         else if (eps < lo) begin
            dist_v = lo;
            st = ST_ENTER;
         end else if (lam < hi) st = ST_FAR;
         else if (eps < hi) begin
            dist_v = hi;
            st = ST_EXIT;
         end else st = ST_BEHIND;
      end
      res.hit = (st == ST_ENTER || st == ST_EXIT);
      res.hit_dist = dist_v[30:0];
      res.status = st;
      return res;
   endfunction

   // input transfers are taken at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_hits.push_back(intersect_cylinder(req_ray, eps_q));
         rays_sent++;
         req_taken = 1'b1;
      end else begin
         req_taken = 1'b0;
      end
   end

   // driver: bursts and gaps, payload held while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold
         end else if (driver_paused || ray_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
            end else burst_left--;
            req_ray <= ray_queue.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // receiver stall pattern; long hold-off on request
   always @(negedge clock) begin
      if (hold_rsp && hold_left == 0) hold_left = 200;
      if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) hold_rsp = 1'b0;
         rsp_stall <= 1'b1;
      end else if (cycle_count % 512 < 128) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      isect_type want;
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycle_count);
         end else begin
            want = expected_hits.pop_front();
            rays_checked++;
            if (rsp_status_code < 5) status_seen[rsp_status_code]++;
            if (rsp_hit !== want.hit || rsp_hit_distance !== want.hit_dist ||
                rsp_status_code !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch ray %0d: hit %0b/%0b dist %0h/%0h status %0d/%0d",
                           rays_checked, want.hit, rsp_hit, want.hit_dist, rsp_hit_distance,
                           want.status, rsp_status_code);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] rnd_q(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // well-aimed ray: origin near cylinder, modest direction
   function automatic ray_type aimed_ray();
      ray_type r;
      r.ox = rnd_q(3 << 16);
      r.oy = rnd_q(3 << 16);
      r.oz = rnd_q(2 << 16) + 32'sh8000;
      r.dx = rnd_q(2 << 16);
      r.dy = rnd_q(2 << 16);
      r.dz = ($urandom_range(0, 5) == 0) ? rnd_q(4) : rnd_q(2 << 16);
      r.lam = 31'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 8 << 16));
      return r;
   endfunction

   function automatic ray_type noise_ray();
      ray_type r;
      r.ox = $urandom(); r.oy = $urandom(); r.oz = $urandom();
      r.dx = $urandom(); r.dy = $urandom(); r.dz = $urandom();
      r.lam = 31'($urandom());
      return r;
   endfunction

   function automatic ray_type mk(int ox, int oy, int oz, int dx, int dy, int dz, int lam);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      r.lam = lam[30:0];
      return r;
   endfunction

   task automatic drain();
      driver_paused = 1'b0;
      wait (ray_queue.size() == 0 && !req_valid);
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_eps(logic [15:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      eps_q = v;
   endtask

   initial begin
      logic [15:0] eps_list[5];
      int base_sent;
      eps_list = '{16'd0, 16'd1, 16'd37, 16'd4096, 16'hffff};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: enter, exit, behind, too far, flat, parallel in/out, extremes
      ray_queue.push_back(mk(-3 << 16, 0, 32'h8000, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(0, 0, 32'h8000, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(3 << 16, 0, 32'h8000, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, 32'h8000, 1 << 16, 0, 0, 1 << 16));
      ray_queue.push_back(mk(0, 0, 32'h8000, 0, 0, 1 << 16, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, 5 << 16, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, -1 << 16, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, -1 << 16, 1 << 16, 0, 1 << 16, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, 2 << 16, 1 << 16, 0, -1 << 16, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 5 << 16, 32'h8000, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      ray_queue.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 0));
      ray_queue.push_back(mk(-1, -1, -1, -1, -1, -1, 32'h7fffffff));
      ray_queue.push_back(mk(0, 0, 0, 1, 1, 1, 0));
      ray_queue.push_back(mk(-3 << 16, 0, 0, 1 << 16, 0, 0, 10 << 16));
      ray_queue.push_back(mk(-3 << 16, 0, 1 << 16, 1 << 16, 0, 0, 10 << 16));
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_eps(eps_list[ph]);
         base_sent = rays_sent;
         for (int i = 0; i < N_RANDOM / 5; i++)
            ray_queue.push_back($urandom_range(0, 4) == 0 ? noise_ray() : aimed_ray());
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps offering rays
            wait (rays_sent > base_sent + 30);
            hold_rsp = 1'b1;
         end
         if (ph == 3) begin
            // sender pause until all outstanding results have come back
            wait (rays_sent > base_sent + 50);
            driver_paused = 1'b1;
            wait (!req_valid);
            while (expected_hits.size() != 0) @(posedge clock);
         end
         drain();
      end
      write_eps(16'($urandom()));
      for (int i = 0; i < 60; i++) ray_queue.push_back(aimed_ray());
      drain();

      $display("checked %0d rays over several epsilon settings", rays_checked);
      $display("miss %0d, far %0d, enter %0d, exit %0d, behind %0d", status_seen[0],
               status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

[ray_capped_cylinder_intersect.f]
hdl/rcyl_pkg.sv
hdl/ray_capped_cylinder_intersect.sv
dv/tb.sv
